// ===== design/kvts_pkg.sv =====
// shared types, codes and defaults for the key-value table store
package kvts_pkg;

    // default sizing
    localparam int CAPACITY_DEF   = 128;
    localparam int KEY_BITS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 64;

    // width of the key, value and read_value fields on the ports
    localparam int FIELD_W = 64;

    // request codes
    localparam logic [1:0] REQ_PUT    = 2'd0;
    localparam logic [1:0] REQ_GET    = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    // status codes
    localparam logic [1:0] ST_EXISTED   = 2'd0;
    localparam logic [1:0] ST_INSERTED  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] value;
    } kvts_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] read_value;
    } kvts_rsp_t;

endpackage

// ===== design/key_value_table_store_core.sv =====
// top level of the key-value table store: two entry rams and the request sequencer
//
// A fixed-capacity table of key/value pairs kept in two single-read-port synchronous
// rams (keys and values, registered read) and searched in order from entry 0
// up to the current count. A transaction is accepted when start is high and busy is
// low; its result appears on rsp for exactly one cycle with done high and cannot be
// held off, so the receiver must take it then. On an empty table a request resolves
// without reading an entry; otherwise it reads entries in order until its key matches
// or the count is reached, and a delete that hits adds a step to fetch and move the
// last entry. The worst case is a full search plus that move, set by the one read
// port of the key ram that the linear search walks through one entry per cycle. Busy
// drops in the cycle done is shown, so the next transaction can be accepted while the
// result is on the ports. Writes land at the edge that raises done, so a following
// transaction always reads the updated table. Keys and values are taken in their low
// KEY_BITS and VALUE_BITS bits; read_value is zero-extended and is zero unless a get
// finds its key. After reset the table is empty; the rams need no clearing since
// entries at or above the count never affect a result.
module key_value_table_store_core
    import kvts_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  kvts_req_t req,
    output logic      done,
    output kvts_rsp_t rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // shared read address, both rams are read at the same entry
    logic [IDX_W-1:0]      mem_raddr;

    // key ram port
    logic                  key_we;
    logic [IDX_W-1:0]      key_waddr;
    logic [KEY_BITS-1:0]   key_wdata;
    logic [KEY_BITS-1:0]   key_rdata;

    // value ram port
    logic                  val_we;
    logic [IDX_W-1:0]      val_waddr;
    logic [VALUE_BITS-1:0] val_wdata;
    logic [VALUE_BITS-1:0] val_rdata;

    // sequencer: scans the key ram, resolves the request, writes back
    kvts_seq #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .mem_raddr (mem_raddr),
        .key_we    (key_we),
        .key_waddr (key_waddr),
        .key_wdata (key_wdata),
        .key_rdata (key_rdata),
        .val_we    (val_we),
        .val_waddr (val_waddr),
        .val_wdata (val_wdata),
        .val_rdata (val_rdata)
    );

    // stored keys
    kvts_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_BITS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (mem_raddr),
        .rdata (key_rdata)
    );

    // stored values
    kvts_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_BITS)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (mem_raddr),
        .rdata (val_rdata)
    );

`ifndef SYNTHESIS
    // an accepted transaction keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not make the block busy");

    // a result only follows a cycle of work
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    // read_value carries data only for a found key
    a_value_only_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != ST_EXISTED)) |-> (rsp.read_value == '0))
        else $error("nonzero read_value on a result that did not find its key");
`endif

endmodule

// ===== design/kvts_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read per cycle
module kvts_ram
    import kvts_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int WIDTH = KEY_BITS_DEF,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [IDX_W-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/kvts_seq.sv =====
// request sequencer: scan, resolve and write-back for the key-value table
module kvts_seq
    import kvts_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W = $clog2(CAPACITY + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  kvts_req_t             req,
    output logic                  done,
    output kvts_rsp_t             rsp,
    output logic [IDX_W-1:0]      mem_raddr,
    output logic                  key_we,
    output logic [IDX_W-1:0]      key_waddr,
    output logic [KEY_BITS-1:0]   key_wdata,
    input  logic [KEY_BITS-1:0]   key_rdata,
    output logic                  val_we,
    output logic [IDX_W-1:0]      val_waddr,
    output logic [VALUE_BITS-1:0] val_wdata,
    input  logic [VALUE_BITS-1:0] val_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMPTY,
        S_SCAN,
        S_DEL_WR
    } state_t;

    state_t                state_reg;
    logic [1:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [IDX_W-1:0]      addr_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  done_reg;
    kvts_rsp_t             rsp_reg;

    logic                  match;
    logic                  scan_last;
    logic                  resolve;
    logic                  not_full;
    logic [IDX_W-1:0]      count_idx;
    logic [IDX_W-1:0]      last_idx;

    // key data at the output of the ram belongs to addr_reg
    assign match     = (state_reg == S_SCAN) && (key_rdata == key_reg);
    assign scan_last = (CNT_W'(addr_reg) + CNT_W'(1)) == count_reg;
    assign resolve   = ((state_reg == S_SCAN) && (match || scan_last))
                       || (state_reg == S_EMPTY);
    assign not_full  = count_reg != CNT_W'(CAPACITY);
    assign count_idx = count_reg[IDX_W-1:0];
    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));

    // read address: next entry during the scan, last entry for a delete hit
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  mem_raddr = '0;
            S_SCAN:
            begin
                if (match && (op_reg == REQ_DELETE))
                    mem_raddr = last_idx;
                else
                    mem_raddr = addr_reg + IDX_W'(1);
            end
            default: mem_raddr = addr_reg;
        endcase
    end

    // write-back
    always_comb
    begin
        key_we    = 1'b0;
        key_waddr = count_idx;
        key_wdata = key_reg;
        val_we    = 1'b0;
        val_waddr = count_idx;
        val_wdata = value_reg;
        if (state_reg == S_DEL_WR)
        begin
            key_we    = 1'b1;
            key_waddr = slot_reg;
            key_wdata = key_rdata;
            val_we    = 1'b1;
            val_waddr = slot_reg;
            val_wdata = val_rdata;
        end
        else if (resolve && (op_reg == REQ_PUT))
        begin
            if (match)
            begin
                val_we    = 1'b1;
                val_waddr = addr_reg;
            end
            else if (not_full)
            begin
                key_we = 1'b1;
                val_we = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= REQ_PUT;
            key_reg    <= '0;
            value_reg  <= '0;
            addr_reg   <= '0;
            slot_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            rsp_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= req.req_type;
                        key_reg   <= req.key[KEY_BITS-1:0];
                        value_reg <= req.value[VALUE_BITS-1:0];
                        addr_reg  <= '0;
                        state_reg <= (count_reg == '0) ? S_EMPTY : S_SCAN;
                    end
                end
                S_EMPTY, S_SCAN:
                begin
                    if (!resolve)
                    begin
                        addr_reg <= addr_reg + IDX_W'(1);
                    end
                    else
                    begin
                        state_reg          <= S_IDLE;
                        done_reg           <= 1'b1;
                        rsp_reg.status     <= ST_NOT_FOUND;
                        rsp_reg.read_value <= '0;
                        unique case (op_reg)
                            REQ_PUT:
                            begin
                                if (match)
                                    rsp_reg.status <= ST_EXISTED;
                                else if (not_full)
                                begin
                                    rsp_reg.status <= ST_INSERTED;
                                    count_reg      <= count_reg + CNT_W'(1);
                                end
                                else
                                    rsp_reg.status <= ST_FULL;
                            end
                            REQ_GET:
                            begin
                                if (match)
                                begin
                                    rsp_reg.status     <= ST_EXISTED;
                                    rsp_reg.read_value <= FIELD_W'(val_rdata);
                                end
                            end
                            REQ_DELETE:
                            begin
                                if (match)
                                begin
                                    // fetch the last entry, answer after moving it
                                    slot_reg  <= addr_reg;
                                    state_reg <= S_DEL_WR;
                                    done_reg  <= 1'b0;
                                end
                            end
                            default:
                            begin
                                rsp_reg.status <= ST_NOT_FOUND;
                            end
                        endcase
                    end
                end
                S_DEL_WR:
                begin
                    count_reg          <= count_reg - CNT_W'(1);
                    state_reg          <= S_IDLE;
                    done_reg           <= 1'b1;
                    rsp_reg.status     <= ST_EXISTED;
                    rsp_reg.read_value <= '0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== tb/key_value_table_store_core_test.sv =====
// self-checking testbench for the key-value table store core
`timescale 1ns / 100ps

module key_value_table_store_core_test;
    import kvts_pkg::*;

    // table depth of the default build and the masks that the core applies to keys and values
    localparam int TABLE_DEPTH = CAPACITY_DEF;
    localparam logic [FIELD_W-1:0] KEY_MASK =
        (KEY_BITS_DEF >= 64) ? '1 : ((64'd1 << KEY_BITS_DEF) - 64'd1);
    localparam logic [FIELD_W-1:0] VALUE_MASK =
        (VALUE_BITS_DEF >= 64) ? '1 : ((64'd1 << VALUE_BITS_DEF) - 64'd1);

    // request code that the core must treat as a no-op miss
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // worst case latency is a full search plus the move of the last entry
    localparam int MAX_LATENCY = TABLE_DEPTH + 2;
    localparam int DRAIN_LIMIT = 4 * MAX_LATENCY;

    // overall run limit in ns, well above the slowest legal run
    localparam longint RUN_LIMIT_NS = 64'd25_000_000;

    typedef enum int {GROW, CHURN, SHRINK} traffic_mode_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    kvts_req_t req = '0;
    logic      done;
    kvts_rsp_t rsp;

    // shadow copy of the table, updated at each accepted transaction
    logic [FIELD_W-1:0] shadow_keys [TABLE_DEPTH];
    logic [FIELD_W-1:0] shadow_values [TABLE_DEPTH];
    int                 shadow_count;

    // responses predicted for accepted transactions, oldest first
    kvts_rsp_t pending_rsps [$];
    int        fail_count;

    // percentage of cycles in which the sender holds off before raising start
    int sender_idle_pct;

    key_value_table_store_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit: a hung core never raises done again
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // apply one transaction to the shadow table and return the response it must produce
    function automatic kvts_rsp_t apply_to_shadow(input kvts_req_t r);
        kvts_rsp_t          exp_rsp;
        logic [FIELD_W-1:0] k;
        logic [FIELD_W-1:0] v;
        int                 slot;
        int                 last;

        k = r.key & KEY_MASK;
        v = r.value & VALUE_MASK;
        exp_rsp.status = ST_NOT_FOUND;
        exp_rsp.read_value = '0;

        // linear search, lowest matching slot wins
        slot = -1;
        for (int i = 0; i < shadow_count; i++)
        begin
            if (slot < 0 && shadow_keys[i] == k)
                slot = i;
        end

        case (r.req_type)
            REQ_PUT:
            begin
                if (slot >= 0)
                begin
                    shadow_values[slot] = v;
                    exp_rsp.status = ST_EXISTED;
                end
                else if (shadow_count < TABLE_DEPTH)
                begin
                    shadow_keys[shadow_count] = k;
                    shadow_values[shadow_count] = v;
                    shadow_count++;
                    exp_rsp.status = ST_INSERTED;
                end
                else
                    exp_rsp.status = ST_FULL;
            end
            REQ_GET:
            begin
                if (slot >= 0)
                begin
                    exp_rsp.read_value = shadow_values[slot];
                    exp_rsp.status = ST_EXISTED;
                end
            end
            REQ_DELETE:
            begin
                // the last entry fills the hole, possibly moving onto itself
                if (slot >= 0 && shadow_count > 0)
                begin
                    last = shadow_count - 1;
                    shadow_keys[slot] = shadow_keys[last];
                    shadow_values[slot] = shadow_values[last];
                    shadow_count = last;
                    exp_rsp.status = ST_EXISTED;
                end
            end
            default:
            begin
                // unused code: no change, reported as a miss
            end
        endcase
        return exp_rsp;
    endfunction

    // present one transaction and record its predicted response once accepted
    task automatic send_request(input logic [1:0] op, input logic [FIELD_W-1:0] k,
                                input logic [FIELD_W-1:0] v);
        kvts_req_t r;
        int        gap;

        r.req_type = op;
        r.key = k;
        r.value = v;

        // mostly short gaps, now and then one long enough to land late in a search
        gap = 0;
        if (sender_idle_pct > 0 && $urandom_range(15) == 0 &&
            $urandom_range(99) < sender_idle_pct)
            gap = $urandom_range(MAX_LATENCY + 8, 1);
        else
        begin
            while (gap < 8 && $urandom_range(99) < sender_idle_pct)
                gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end

        start <= 1'b1;
        req <= r;
        // accepted at the first edge that sees start high and busy low
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_rsps.push_back(apply_to_shadow(r));
    endtask

    // hold the sender off until every predicted response has come back or the drain limit is reached
    task automatic wait_for_results();
        int waited;

        start <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pending_rsps.size() != 0 && waited < DRAIN_LIMIT);
    endtask

    // response checker: done marks a single-cycle result that must be taken at once
    always @(posedge clk)
    begin
        kvts_rsp_t exp_rsp;

        if (rst_n && done)
        begin
            if (pending_rsps.size() == 0)
            begin
                $display("%0t: unexpected response: expected none, got status %0d value %h",
                         $time, rsp.status, rsp.read_value);
                fail_count++;
            end
            else
            begin
                exp_rsp = pending_rsps.pop_front();
                if (rsp.status !== exp_rsp.status)
                begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, exp_rsp.status, rsp.status);
                    fail_count++;
                end
                if (rsp.read_value !== exp_rsp.read_value)
                begin
                    $display("%0t: read_value mismatch: expected %h, got %h",
                             $time, exp_rsp.read_value, rsp.read_value);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [FIELD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // a key currently held in the table, or a fresh one if the table is empty
    function automatic logic [FIELD_W-1:0] stored_key();
        if (shadow_count == 0)
            return random_word();
        return shadow_keys[$urandom_range(shadow_count - 1)];
    endfunction

    // misses, deletes and the unused code on an empty table
    task automatic test_empty_table();
        send_request(REQ_GET, '1, '0);
        send_request(REQ_DELETE, '1, '1);
        send_request(REQ_UNUSED, '0, '1);
    endtask

    // insert at both key extremes, update in place, unused code leaves the entry alone
    task automatic test_insert_update_get();
        send_request(REQ_PUT, '1, '1);
        send_request(REQ_PUT, '0, '0);
        send_request(REQ_GET, '1, '0);
        send_request(REQ_GET, '0, '1);
        send_request(REQ_PUT, '0, 64'ha5a5_5a5a_c3c3_3c3c);
        send_request(REQ_GET, '0, '0);
        send_request(REQ_UNUSED, '0, '1);
        send_request(REQ_GET, '0, '0);
        send_request(REQ_PUT, 64'h8000_0000_0000_0001, 64'h5555_aaaa_5555_aaaa);
    endtask

    // delete moves the last entry into the hole; deleting the last slot shrinks in place
    task automatic test_delete_moves_last();
        send_request(REQ_DELETE, '1, '0);
        send_request(REQ_GET, 64'h8000_0000_0000_0001, '0);
        send_request(REQ_GET, '1, '0);
        send_request(REQ_DELETE, 64'h8000_0000_0000_0001, '0);
        send_request(REQ_DELETE, '0, '0);
        send_request(REQ_GET, '0, '0);
        send_request(REQ_DELETE, '0, '0);
    endtask

    // fill the table, then check the full report and that hits still work when full
    task automatic test_table_full();
        logic [FIELD_W-1:0] k;

        while (shadow_count < TABLE_DEPTH)
            send_request(REQ_PUT, random_word(), random_word());
        send_request(REQ_PUT, random_word(), random_word());
        k = stored_key();
        send_request(REQ_PUT, k, random_word());
        send_request(REQ_GET, k, random_word());
        send_request(REQ_GET, shadow_keys[TABLE_DEPTH-1], '0);
        send_request(REQ_DELETE, k, random_word());
        send_request(REQ_PUT, random_word(), random_word());
        send_request(REQ_PUT, random_word(), random_word());
    endtask

    // mixed traffic in bursts that grow, churn or drain the table
    task automatic test_random_traffic(input int count, input int idle_pct);
        traffic_mode_t      mode;
        int                 pick;
        int                 hit_pct;
        logic [1:0]         op;
        logic [FIELD_W-1:0] k;

        sender_idle_pct = idle_pct;
        mode = CHURN;
        for (int n = 0; n < count; n++)
        begin
            if (n % 48 == 0)
                mode = traffic_mode_t'($urandom_range(2));

            pick = $urandom_range(99);
            case (mode)
                GROW:
                begin
                    hit_pct = 30;
                    op = (pick < 70) ? REQ_PUT : (pick < 88) ? REQ_GET :
                         (pick < 96) ? REQ_DELETE : REQ_UNUSED;
                end
                SHRINK:
                begin
                    hit_pct = 75;
                    op = (pick < 15) ? REQ_PUT : (pick < 38) ? REQ_GET :
                         (pick < 96) ? REQ_DELETE : REQ_UNUSED;
                end
                default:
                begin
                    hit_pct = 65;
                    op = (pick < 32) ? REQ_PUT : (pick < 64) ? REQ_GET :
                         (pick < 96) ? REQ_DELETE : REQ_UNUSED;
                end
            endcase

            // stored keys for hits, full random words and a few small keys that collide
            pick = $urandom_range(99);
            if (pick < hit_pct)
                k = stored_key();
            else if (pick < hit_pct + 8)
                k = FIELD_W'($urandom_range(15));
            else
                k = random_word();

            send_request(op, k, random_word());

            // now and then let the core go quiet before the next transaction
            if ($urandom_range(59) == 0)
                wait_for_results();
        end
    endtask

    initial
    begin
        fail_count = 0;
        shadow_count = 0;
        sender_idle_pct = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_insert_update_get();
        test_delete_moves_last();
        wait_for_results();

        sender_idle_pct = 32;
        test_table_full();
        wait_for_results();

        test_random_traffic(590, 32);
        wait_for_results();
        test_random_traffic(590, 55);
        wait_for_results();
        test_random_traffic(590, 0);

        // let the last transaction finish and catch any stray response
        wait_for_results();
        repeat (MAX_LATENCY + 4) @(posedge clk);
        if (pending_rsps.size() != 0)
        begin
            $display("%0t: missing responses: expected %0d more, got none",
                     $time, pending_rsps.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
